[hdl/imsm_pkg.sv]
package imsm_pkg;

  // Field widths
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_BITS  = 24;
  localparam int TARGET_BITS = 16;
  localparam int MEAN_BITS   = 32;
  localparam int NUM_AXES    = 6;
  localparam int AXES_PER_SENSOR = 3;

  // Difference of scaled sample and mean, one guard bit for the sign
  localparam int SCALED_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int DIFF_BITS   = ((SCALED_BITS > MEAN_BITS) ? SCALED_BITS : MEAN_BITS) + 1;
  localparam int MAG_BITS    = DIFF_BITS - 1;
  localparam int SUM_BITS    = DIFF_BITS + 1;

  // Serial divider step counter
  localparam int STEP_W = $clog2(MAG_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_BITS - 1);

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NED_SWAP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET   = 2'd2;

  // Reset values
  localparam logic [TARGET_BITS-1:0] TARGET_INIT = TARGET_BITS'(100);
  localparam logic [MEAN_BITS-1:0]   MEAN_Z_INIT = -(MEAN_BITS'(1) << FRAC_BITS);
  localparam int AXIS_ACCEL_Z = 2;

  // Divider request and result
  typedef struct packed {
    logic                  start;
    logic [MAG_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [MAG_BITS-1:0] quotient;
  } div_res_t;

endpackage

[hdl/imsm_div.sv]
// Restoring unsigned divider, one quotient bit per cycle
module imsm_div (
  input  logic               clk,
  input  logic               rst,
  input  imsm_pkg::div_req_t req,
  output imsm_pkg::div_res_t res
);
  import imsm_pkg::*;

  logic                  busy;
  logic                  done;
  logic [STEP_W-1:0]     step;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] divisor;
  logic [MAG_BITS-1:0]   quo;
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS+1:0] trial;

  // Bring down the next dividend bit and try the subtract
  assign shifted = {rem, quo[MAG_BITS-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        step    <= '0;
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        if (!trial[COUNT_BITS+1]) begin
          rem <= trial[COUNT_BITS-1:0];
          quo <= {quo[MAG_BITS-2:0], 1'b1};
        end else begin
          rem <= shifted[COUNT_BITS-1:0];
          quo <= {quo[MAG_BITS-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done     = done;
  assign res.quotient = quo;

endmodule

[hdl/imu_static_mean_init.sv]
// Channel  Dir  Width  Contents
// s_*      in   96+1   six raw samples in tdata, package end in tlast
// m_*      out  192+1  six Q16.16 means in tdata, ready flag in tuser
// cfg_*    in   2+16   register index and write data
//
// A word taken while averaging runs six axes through one serial divider,
// one quotient bit a cycle. Once averaging is done, a word is only taken,
// and a package end starts a report; while disabled, words are dropped.
// A new word is taken only when the previous one is finished; a pending
// result waits in the output register and stalls only the next report.
// Reset is synchronous and needs no clearing pass.
module imu_static_mean_init (
  input  logic                                             clk,
  input  logic                                             rst,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  input  logic [imsm_pkg::NUM_AXES*imsm_pkg::SAMPLE_BITS-1:0] s_tdata,
  input  logic                                             s_tlast,
  input  logic                                             s_tvalid,
  output logic                                             s_tready,
  // mean_accel_x .. mean_gyro_z (32 bits each)
  output logic [imsm_pkg::NUM_AXES*imsm_pkg::MEAN_BITS-1:0] m_tdata,
  // ready_res
  output logic                                             m_tuser,
  output logic                                             m_tvalid,
  input  logic                                             m_tready,
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  input  logic [imsm_pkg::CFG_INDEX_W-1:0]                 cfg_index,
  input  logic [imsm_pkg::CFG_DATA_W-1:0]                  cfg_data
);
  import imsm_pkg::*;

  localparam int AXIS_W = $clog2(NUM_AXES);
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIFF   = 3'd1;
  localparam logic [2:0] ST_DIVST  = 3'd2;
  localparam logic [2:0] ST_DIVW   = 3'd3;
  localparam logic [2:0] ST_APPLY  = 3'd4;
  localparam logic [2:0] ST_COUNT  = 3'd5;
  localparam logic [2:0] ST_REPORT = 3'd6;

  // Negate with saturation of the most negative code
  function automatic logic signed [SAMPLE_BITS-1:0] sat_neg(
    input logic signed [SAMPLE_BITS-1:0] v
  );
    logic signed [SAMPLE_BITS-1:0] r;
    if (v == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    else r = -v;
    return r;
  endfunction

  logic [2:0]                     state;
  logic [AXIS_W-1:0]              axis;
  logic                           enable;
  logic                           ned_swap;
  logic [TARGET_BITS-1:0]         sample_target;
  logic [COUNT_BITS-1:0]          sample_count;
  logic                           done_flag;
  logic                           last_flag;
  logic                           diff_neg;
  logic signed [MEAN_BITS-1:0]    mean [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0]  samp [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0]  raw  [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0]  swp  [NUM_AXES];
  logic signed [DIFF_BITS-1:0]    diff;
  logic        [DIFF_BITS-1:0]    diff_abs;
  logic signed [DIFF_BITS-1:0]    qsig;
  logic signed [SCALED_BITS-1:0]  scaled;
  logic signed [SUM_BITS-1:0]     sum;
  logic signed [MEAN_BITS-1:0]    mean_next;
  logic                           s_accept;
  logic                           slot_free;
  logic                           done_next;
  div_req_t                       div_req;
  div_res_t                       div_res;

  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign slot_free = !m_tvalid || m_tready;

  // Unpack and optional NED to ENU conversion per sensor triple
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      raw[i] = s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      swp[i] = raw[i];
    end
    if (ned_swap) begin
      for (int g = 0; g < NUM_AXES; g += AXES_PER_SENSOR) begin
        swp[g]     = raw[g+1];
        swp[g+1]   = raw[g];
        swp[g+2]   = sat_neg(raw[g+2]);
      end
    end
  end

  // Datapath for the axis at the head of the ring
  assign scaled   = $signed({samp[0], {FRAC_BITS{1'b0}}});
  assign diff_abs = diff[DIFF_BITS-1] ? -diff : diff;
  assign sum      = SUM_BITS'(mean[0]) + SUM_BITS'(qsig);

  // Saturate the new mean to the output range
  always_comb begin
    if (sum[SUM_BITS-1:MEAN_BITS-1] == '0 || sum[SUM_BITS-1:MEAN_BITS-1] == '1)
      mean_next = sum[MEAN_BITS-1:0];
    else if (sum[SUM_BITS-1])
      mean_next = {1'b1, {(MEAN_BITS-1){1'b0}}};
    else
      mean_next = {1'b0, {(MEAN_BITS-1){1'b1}}};
  end

  assign done_next = done_flag || (sample_count > COUNT_BITS'(sample_target));

  assign div_req.start    = (state == ST_DIVST);
  assign div_req.dividend = diff_abs[MAG_BITS-1:0];
  assign div_req.divisor  = sample_count;

  imsm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b1;
      ned_swap      <= 1'b0;
      sample_target <= TARGET_INIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:   enable        <= cfg_data[0];
        REG_NED_SWAP: ned_swap      <= cfg_data[0];
        REG_TARGET:   sample_target <= cfg_data[TARGET_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // Sequencer, mean ring and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      axis         <= '0;
      sample_count <= COUNT_BITS'(1);
      done_flag    <= 1'b0;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++)
        mean[i] <= (i == AXIS_ACCEL_Z) ? MEAN_Z_INIT : '0;
    end else begin
      // report state reloads the output register itself
      if (m_tvalid && m_tready && state != ST_REPORT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            last_flag <= s_tlast;
            for (int i = 0; i < NUM_AXES; i++) samp[i] <= swp[i];
            if (enable) begin
              if (!done_flag) begin
                axis  <= '0;
                state <= ST_DIFF;
              end else if (s_tlast) begin
                state <= ST_REPORT;
              end
            end
          end
        end
        ST_DIFF: begin
          diff  <= DIFF_BITS'(scaled) - DIFF_BITS'(mean[0]);
          state <= ST_DIVST;
        end
        ST_DIVST: begin
          diff_neg <= diff[DIFF_BITS-1];
          state    <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_res.done) begin
            qsig  <= diff_neg ? -$signed({1'b0, div_res.quotient})
                              : $signed({1'b0, div_res.quotient});
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          // rotate ring: updated mean goes to the tail
          for (int i = 0; i < NUM_AXES - 1; i++) begin
            mean[i] <= mean[i+1];
            samp[i] <= samp[i+1];
          end
          mean[NUM_AXES-1] <= mean_next;
          samp[NUM_AXES-1] <= samp[0];
          if (axis == LAST_AXIS) begin
            state <= ST_COUNT;
          end else begin
            axis  <= axis + 1'b1;
            state <= ST_DIFF;
          end
        end
        ST_COUNT: begin
          if (sample_count != '1) sample_count <= sample_count + 1'b1;
          state <= last_flag ? ST_REPORT : ST_IDLE;
        end
        ST_REPORT: begin
          if (slot_free) begin
            for (int i = 0; i < NUM_AXES; i++)
              m_tdata[i*MEAN_BITS +: MEAN_BITS] <= mean[i];
            m_tuser   <= done_next;
            done_flag <= done_next;
            m_tvalid  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // averaging never resumes once finished
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag)
    else $error("done flag cleared");

  // divisor is never zero
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    sample_count != '0)
    else $error("sample count reached zero");

  // frozen means are never rewritten
  a_no_update_when_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> !done_flag)
    else $error("mean update after averaging finished");

  // a pending result is never overwritten
  a_report_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && m_tvalid && !m_tready) |=> (state == ST_REPORT))
    else $error("report issued over a pending result");
`endif

endmodule
